FILE: sv/aibt_pkg.sv
package aibt_pkg;

   // field widths
   localparam int OP_W    = 2;
   localparam int INDEX_W = 8;
   localparam int VALUE_W = 16;
   localparam int ID_W    = 12;
   localparam int STAT_W  = 2;

   // request codes
   localparam logic [OP_W-1:0] OP_BIND   = 2'd0;
   localparam logic [OP_W-1:0] OP_UNBIND = 2'd1;
   localparam logic [OP_W-1:0] OP_SET    = 2'd2;
   localparam logic [OP_W-1:0] OP_GET    = 2'd3;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INVAL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOSPACE  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

   // allocation id range and the id returned for a free slot
   localparam int unsigned       ALLOC_ID_LIMIT = 32'd4096;
   localparam logic [ID_W-1:0]   UNASSIGNED_ID  = 12'd255;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic issue;
      logic finish;
   } aibt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } aibt_sts_type;

endpackage

FILE: sv/aibt_ctrl.sv
module aibt_ctrl
   import aibt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  aibt_sts_type sts,
   output aibt_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_LAST = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sts.scan_last) state_in = S_LAST;
         end
         S_LAST: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign req_stall  = (state_ff != S_IDLE);
   assign cmd.start  = (state_ff == S_IDLE) && req_valid;
   assign cmd.issue  = (state_ff == S_SCAN);
   assign cmd.finish = (state_ff == S_DONE) && sts.out_free;

endmodule

FILE: sv/aibt_datapath.sv
module aibt_datapath
   import aibt_pkg::*;
#(
   parameter int SLOT_COUNT = 32
)
(
   input  logic                clock,
   input  logic                reset,
   input  aibt_cmd_type        cmd,
   output aibt_sts_type        sts,
   input  logic [OP_W-1:0]     req_op,
   input  logic [INDEX_W-1:0]  req_slot_index,
   input  logic [VALUE_W-1:0]  req_alloc_value,
   input  logic                req_mark_valid,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [INDEX_W-1:0]  rsp_result_index,
   output logic [ID_W-1:0]     rsp_read_id,
   output logic                rsp_read_valid
);

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // latched request word
   logic [OP_W-1:0]    op_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [VALUE_W-1:0] val_ff;
   logic               mv_ff;

   // scan state
   logic [IW-1:0]      cnt_ff;
   logic               cmp_vld_ff;
   logic [IW-1:0]      cmp_idx_ff;
   logic [ID_W-1:0]    rd_data_ff;
   logic               hit_ff;
   logic [IW-1:0]      hit_idx_ff;

   // slot table: ids in memory, valid bits in flops
   logic [ID_W-1:0]       id_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff;

   // response register
   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [ID_W-1:0]    rsp_id_ff;
   logic               rsp_rvld_ff;

   logic               is_bind;
   logic               scan_op;
   logic               idx_ok;
   logic               val_ok;
   logic [IW-1:0]      slot_addr;
   logic [IW-1:0]      rd_addr;
   logic               rd_en;
   logic               cmp_v;
   logic               cmp_match;
   logic               cand;
   logic               clr_en;
   logic               get_vbit;

   // commit controls
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   logic               vwr_en;
   logic [IW-1:0]      vwr_idx;
   logic               vwr_bit;
   logic [STAT_W-1:0]  status_in;
   logic [INDEX_W-1:0] index_in;
   logic [ID_W-1:0]    id_in;
   logic               rvld_in;

   // request decode
   assign is_bind   = (op_ff == OP_BIND);
   assign scan_op   = (op_ff == OP_BIND) || (op_ff == OP_UNBIND);
   assign idx_ok    = ({1'b0, idx_ff} < (INDEX_W+1)'(SLOT_COUNT));
   assign val_ok    = ({16'd0, val_ff} < ALLOC_ID_LIMIT);
   assign slot_addr = idx_ff[IW-1:0];

   // scan address and read enable
   assign rd_addr = scan_op ? cnt_ff : slot_addr;
   assign rd_en   = cmd.issue && (scan_op || idx_ok);

   assign sts.scan_last = !scan_op || (cnt_ff == IW'(SLOT_COUNT - 1));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // compare stage: match on a valid slot; for bind, a free or matching slot other than slot zero is a candidate
   assign cmp_v     = valid_ff[cmp_idx_ff];
   assign cmp_match = cmp_v && ({4'd0, rd_data_ff} == val_ff);
   assign cand      = is_bind ? ((cmp_idx_ff != '0) && (!cmp_v || cmp_match)) : cmp_match;
   assign clr_en    = cmp_vld_ff && is_bind && cmp_match;

   assign get_vbit = valid_ff[slot_addr];

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_op;
         idx_ff <= req_slot_index;
         val_ff <= req_alloc_value;
         mv_ff  <= req_mark_valid;
      end
   end

   // scan counter, compare pipe and first hit
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.issue;
         if (cmd.start) begin
            cnt_ff <= '0;
            hit_ff <= 1'b0;
         end else begin
            if (cmd.issue && !sts.scan_last) cnt_ff <= cnt_ff + 1'b1;
            if (cmp_vld_ff && scan_op && cand && !hit_ff) hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) cmp_idx_ff <= rd_addr;
      if (cmp_vld_ff && scan_op && cand && !hit_ff) hit_idx_ff <= cmp_idx_ff;
   end

   // commit of the finished request
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_addr;
      vwr_en    = 1'b0;
      vwr_idx   = slot_addr;
      vwr_bit   = 1'b0;
      status_in = STAT_OK;
      index_in  = '0;
      id_in     = '0;
      rvld_in   = 1'b0;
      case (op_ff)
         OP_BIND: begin
            mem_waddr = hit_idx_ff;
            vwr_idx   = hit_idx_ff;
            if (!hit_ff) begin
               status_in = STAT_NOSPACE;
            end else if (!val_ok) begin
               status_in = STAT_INVAL;
            end else begin
               mem_we   = 1'b1;
               vwr_en   = 1'b1;
               vwr_bit  = 1'b1;
               index_in = INDEX_W'(hit_idx_ff);
            end
         end
         OP_UNBIND: begin
            vwr_idx = hit_idx_ff;
            if (!hit_ff) begin
               status_in = STAT_NOTFOUND;
            end else begin
               vwr_en   = 1'b1;
               index_in = INDEX_W'(hit_idx_ff);
            end
         end
         OP_SET: begin
            if (!idx_ok || (mv_ff && !val_ok)) begin
               status_in = STAT_INVAL;
            end else begin
               vwr_en  = 1'b1;
               vwr_bit = mv_ff;
               mem_we  = mv_ff;
            end
         end
         default: begin
            if (!idx_ok) begin
               status_in = STAT_INVAL;
            end else begin
               id_in   = get_vbit ? rd_data_ff : UNASSIGNED_ID;
               rvld_in = get_vbit;
            end
         end
      endcase
   end

   // id memory: a free slot always reads as unassigned through its valid bit
   always_ff @(posedge clock) begin
      if (cmd.finish && mem_we) id_mem[mem_waddr] <= val_ff[ID_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= id_mem[rd_addr];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (clr_en) valid_ff[cmp_idx_ff] <= 1'b0;
         if (cmd.finish && vwr_en) valid_ff[vwr_idx] <= vwr_bit;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= status_in;
         rsp_index_ff  <= index_in;
         rsp_id_ff     <= id_in;
         rsp_rvld_ff   <= rvld_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_read_id      = rsp_id_ff;
   assign rsp_read_valid   = rsp_rvld_ff;

   // compare stage only follows a read issue
   a_cmp_follows_issue: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> $past(cmd.issue))
      else $error("compare stage without a read");

   // bind never claims slot zero
   a_bind_not_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && is_bind && hit_ff |-> hit_idx_ff != '0)
      else $error("bind claimed slot zero");

   // successful bind leaves the claimed slot valid
   a_bind_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && is_bind && hit_ff && val_ok |=> valid_ff[$past(hit_idx_ff)])
      else $error("bound slot not valid");

   // successful unbind leaves the slot free
   a_unbind_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && (op_ff == OP_UNBIND) && hit_ff |=> !valid_ff[$past(hit_idx_ff)])
      else $error("unbound slot still valid");

endmodule

FILE: sv/alloc_id_binding_table_unit.sv
// channel   | ports                                          | direction
// ----------+------------------------------------------------+----------
// request   | req_valid, req_stall, req_op, req_slot_index,  | in
//           | req_alloc_value, req_mark_valid                |
// response  | rsp_valid, rsp_stall, rsp_status,              | out
//           | rsp_result_index, rsp_read_id, rsp_read_valid  |
//
// the id memory is scanned one slot per cycle through its single read port,
// so the scan length sets the bind and unbind time.
// one request word is in work at a time; a new one is taken the cycle after
// the previous response is loaded, even while that response is still stalled.
// reset clears the valid bits at once; no memory clearing pass is needed.
module alloc_id_binding_table_unit
   import aibt_pkg::*;
#(
   parameter int SLOT_COUNT = 32
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [INDEX_W-1:0]  req_slot_index,
   input  logic [VALUE_W-1:0]  req_alloc_value,
   input  logic                req_mark_valid,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [INDEX_W-1:0]  rsp_result_index,
   output logic [ID_W-1:0]     rsp_read_id,
   output logic                rsp_read_valid
);

   aibt_cmd_type cmd;
   aibt_sts_type sts;

   // sequencer
   aibt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot table and response
   aibt_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_op),
      .req_slot_index   (req_slot_index),
      .req_alloc_value  (req_alloc_value),
      .req_mark_valid   (req_mark_valid),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_read_id      (rsp_read_id),
      .rsp_read_valid   (rsp_read_valid)
   );

endmodule
